[rtl/rlfs_pkg.sv]
// Shared types and constants for the RGB LED fade/flash sequencer.
// Used by rlfs_seq, rlfs_scale and rgb_led_fade_flash_sequencer_core.
package rlfs_pkg;

    // Field widths fixed by the command format
    localparam int RGB_W    = 24;
    localparam int CH_W     = 8;
    localparam int PAUSE_W  = 16;
    localparam int OP_W     = 3;
    localparam int CFG_IDX_W = 1;

    // Command codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_SET    = 3'd1,
        OP_FADE   = 3'd2,
        OP_FLASH  = 3'd3,
        OP_FLASH2 = 3'd4
    } op_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_LEVEL  = 1'b1;

    // Sequence modes
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_FADE   = 2'd1,
        MODE_FLASH  = 2'd2,
        MODE_FLASH2 = 2'd3
    } mode_t;

    // Flash-twice phases
    typedef enum logic [1:0] {
        PH_SHOW1    = 2'd0,
        PH_RESTORE1 = 2'd1,
        PH_SHOW2    = 2'd2,
        PH_RESTORE2 = 2'd3
    } phase_t;

    // Per-result status carried down the pipeline
    typedef struct packed {
        logic busy;
        logic rejected;
    } status_t;

    // One fade step: the new colour and whether a channel moved
    typedef struct packed {
        logic             moved;
        logic [RGB_W-1:0] rgb;
    } fade_t;

    // Step one channel by one unit toward its target
    function automatic logic [CH_W-1:0] ch_step(input logic [CH_W-1:0] cur,
                                                input logic [CH_W-1:0] tgt);
        ch_step = (cur < tgt) ? cur + 8'd1 : cur - 8'd1;
    endfunction

    // Red first, then green, then blue
    function automatic fade_t fade_step(input logic [RGB_W-1:0] cur,
                                        input logic [RGB_W-1:0] tgt);
        fade_t res;
        res.moved = 1'b1;
        res.rgb   = cur;
        if (cur[23:16] != tgt[23:16]) begin
            res.rgb[23:16] = ch_step(cur[23:16], tgt[23:16]);
        end else if (cur[15:8] != tgt[15:8]) begin
            res.rgb[15:8] = ch_step(cur[15:8], tgt[15:8]);
        end else if (cur[7:0] != tgt[7:0]) begin
            res.rgb[7:0] = ch_step(cur[7:0], tgt[7:0]);
        end else begin
            res.moved = 1'b0;
        end
        fade_step = res;
    endfunction

endpackage

[rtl/rlfs_seq.sv]
// Command sequencer: colour state, fade/flash sequencing and the first
// result register. Depends on rlfs_pkg.
module rlfs_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [rlfs_pkg::OP_W-1:0]   operation,
    input  logic [rlfs_pkg::RGB_W-1:0]  color,
    input  logic [rlfs_pkg::PAUSE_W-1:0] pause,
    output logic [rlfs_pkg::RGB_W-1:0]  res_rgb,
    output rlfs_pkg::status_t           res_status
);
    import rlfs_pkg::*;

    logic [RGB_W-1:0]   current_rgb_reg, current_rgb_next;
    logic [RGB_W-1:0]   target_rgb_reg, target_rgb_next;
    logic [RGB_W-1:0]   saved_rgb_reg, saved_rgb_next;
    logic [RGB_W-1:0]   flash_rgb_reg, flash_rgb_next;
    mode_t              mode_reg, mode_next;
    phase_t             phase_reg, phase_next;
    logic [PAUSE_W-1:0] wait_reg, wait_next;
    logic [PAUSE_W-1:0] pause_reg, pause_next;
    logic               rej_next;
    logic               busy;
    fade_t              tick_step;
    fade_t              start_step;
    logic [RGB_W-1:0]   res_rgb_reg;
    status_t            res_status_reg;
    status_t            status_next;

    assign busy       = (mode_reg != MODE_IDLE);
    assign tick_step  = fade_step(current_rgb_reg, target_rgb_reg);
    assign start_step = fade_step(current_rgb_reg, color);

    // Next state
    always_comb
    begin
        current_rgb_next = current_rgb_reg;
        target_rgb_next  = target_rgb_reg;
        saved_rgb_next   = saved_rgb_reg;
        flash_rgb_next   = flash_rgb_reg;
        mode_next        = mode_reg;
        phase_next       = phase_reg;
        wait_next        = wait_reg;
        pause_next       = pause_reg;
        rej_next         = 1'b0;
        if (load) begin
            unique case (op_t'(operation))
                OP_TICK:
                begin
                    if (busy) begin
                        if (wait_reg > 16'd1) begin
                            wait_next = wait_reg - 16'd1;
                        end else begin
                            wait_next = '0;
                            unique case (mode_reg)
                                MODE_FADE:
                                begin
                                    if (tick_step.moved) begin
                                        current_rgb_next = tick_step.rgb;
                                        wait_next        = pause_reg;
                                    end else begin
                                        mode_next = MODE_IDLE;
                                    end
                                end
                                MODE_FLASH:
                                begin
                                    current_rgb_next = saved_rgb_reg;
                                    mode_next        = MODE_IDLE;
                                end
                                MODE_FLASH2:
                                begin
                                    unique case (phase_reg)
                                        PH_SHOW1:
                                        begin
                                            current_rgb_next = saved_rgb_reg;
                                            phase_next       = PH_RESTORE1;
                                            wait_next        = pause_reg;
                                        end
                                        PH_RESTORE1:
                                        begin
                                            current_rgb_next = flash_rgb_reg;
                                            phase_next       = PH_SHOW2;
                                            wait_next        = pause_reg;
                                        end
                                        PH_SHOW2:
                                        begin
                                            current_rgb_next = saved_rgb_reg;
                                            phase_next       = PH_RESTORE2;
                                            wait_next        = pause_reg;
                                        end
                                        default:
                                        begin
                                            phase_next = PH_SHOW1;
                                            mode_next  = MODE_IDLE;
                                        end
                                    endcase
                                end
                                default:
                                begin
                                    mode_next = MODE_IDLE;
                                end
                            endcase
                        end
                    end
                end
                OP_SET:
                begin
                    if (busy) begin
                        rej_next = 1'b1;
                    end else begin
                        current_rgb_next = color;
                    end
                end
                OP_FADE:
                begin
                    if (busy) begin
                        rej_next = 1'b1;
                    end else begin
                        target_rgb_next = color;
                        pause_next      = pause;
                        phase_next      = PH_SHOW1;
                        if (start_step.moved) begin
                            current_rgb_next = start_step.rgb;
                            mode_next        = MODE_FADE;
                            wait_next        = pause;
                        end
                    end
                end
                OP_FLASH, OP_FLASH2:
                begin
                    if (busy) begin
                        rej_next = 1'b1;
                    end else begin
                        flash_rgb_next   = color;
                        saved_rgb_next   = current_rgb_reg;
                        pause_next       = pause;
                        phase_next       = PH_SHOW1;
                        current_rgb_next = color;
                        wait_next        = pause;
                        mode_next = (op_t'(operation) == OP_FLASH) ? MODE_FLASH
                                                                   : MODE_FLASH2;
                    end
                end
                default:
                begin
                    // unused codes leave everything as is
                end
            endcase
        end
    end

    // Result status
    always_comb
    begin
        status_next.busy     = (mode_next != MODE_IDLE);
        status_next.rejected = rej_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            current_rgb_reg <= '0;
            target_rgb_reg  <= '0;
            saved_rgb_reg   <= '0;
            flash_rgb_reg   <= '0;
            mode_reg        <= MODE_IDLE;
            phase_reg       <= PH_SHOW1;
            wait_reg        <= '0;
            pause_reg       <= '0;
        end else begin
            current_rgb_reg <= current_rgb_next;
            target_rgb_reg  <= target_rgb_next;
            saved_rgb_reg   <= saved_rgb_next;
            flash_rgb_reg   <= flash_rgb_next;
            mode_reg        <= mode_next;
            phase_reg       <= phase_next;
            wait_reg        <= wait_next;
            pause_reg       <= pause_next;
        end
    end

    // First result stage
    always_ff @(posedge clk)
    begin
        if (load) begin
            res_rgb_reg    <= current_rgb_next;
            res_status_reg <= status_next;
        end
    end

    assign res_rgb    = res_rgb_reg;
    assign res_status = res_status_reg;

endmodule

[rtl/rlfs_scale.sv]
// Two-stage PWM level scaling for one colour channel:
// off + ch*(on-off)/255 truncated toward zero. Depends on rlfs_pkg.
module rlfs_scale #(
    parameter int PWM_BITS = 10
) (
    input  logic                      clk,
    input  logic                      load_mul,
    input  logic                      load_out,
    input  logic [rlfs_pkg::CH_W-1:0] ch,
    input  logic [PWM_BITS-1:0]       off_level,
    input  logic [PWM_BITS-1:0]       on_level,
    output logic [PWM_BITS-1:0]       level
);
    import rlfs_pkg::*;

    // floor(m/255) = (m*RECIP) >> RS, exact for m < 255*2**PWM_BITS
    localparam int MW = PWM_BITS + CH_W;
    localparam int RS = PWM_BITS + 16;
    localparam int CW = RS - 7;
    localparam int PW = MW + CW;
    localparam longint unsigned RECIP_L = ((64'd1 << RS) + 64'd254) / 64'd255;
    localparam logic [CW-1:0] RECIP = RECIP_L[CW-1:0];

    logic [PWM_BITS:0]   span;
    logic [PWM_BITS-1:0] mag;
    logic [MW-1:0]       m_reg, m_next;
    logic                neg_reg, neg_next;
    logic [PW-1:0]       prod;
    logic [PWM_BITS-1:0] quo;
    logic [PWM_BITS-1:0] level_reg, level_next;

    // Stage 1: channel times span magnitude
    assign span     = {1'b0, on_level} - {1'b0, off_level};
    assign neg_next = span[PWM_BITS];
    assign mag      = neg_next ? PWM_BITS'(-span) : span[PWM_BITS-1:0];
    assign m_next   = MW'(ch) * MW'(mag);

    always_ff @(posedge clk)
    begin
        if (load_mul) begin
            m_reg   <= m_next;
            neg_reg <= neg_next;
        end
    end

    // Stage 2: divide by 255 via reciprocal, apply sign, add offset
    assign prod       = PW'(m_reg) * PW'(RECIP);
    assign quo        = prod[RS +: PWM_BITS];
    assign level_next = neg_reg ? off_level - quo : off_level + quo;

    always_ff @(posedge clk)
    begin
        if (load_out) begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

[rtl/rgb_led_fade_flash_sequencer_core.sv]
// Top level of the RGB LED fade/flash sequencer: handshake pipeline,
// configuration registers. Depends on rlfs_pkg, rlfs_seq, rlfs_scale.

// One result per input transfer; out_valid rises once the transfer
// has passed the input, multiply and divide stage registers. A new
// command or tick is taken every cycle unless all stages stall. The colour
// state updates in the input stage, then each channel goes through a
// multiply stage (channel times level span) and a reciprocal divide-by-255
// stage into the output register. Each stage stalls only when the one
// after it is full, so input keeps flowing while a result waits.
// pwm_off_level and pwm_on_level are written at index 0 and 1 and must
// only be changed while no transfer is in flight.
module rgb_led_fade_flash_sequencer_core #(
    parameter int PWM_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rlfs_pkg::OP_W-1:0]     operation,
    input  logic [rlfs_pkg::RGB_W-1:0]    color,
    input  logic [rlfs_pkg::PAUSE_W-1:0]  pause,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [PWM_BITS-1:0]           red_drive,
    output logic [PWM_BITS-1:0]           green_drive,
    output logic [PWM_BITS-1:0]           blue_drive,
    output logic                          busy_res,
    output logic                          rejected,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rlfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [PWM_BITS-1:0]           cfg_data
);
    import rlfs_pkg::*;

    logic                v1_reg, v1_next;
    logic                v2_reg, v2_next;
    logic                v3_reg, v3_next;
    logic                rdy1, rdy2, rdy3;
    logic                load1, load2, load3;
    logic [PWM_BITS-1:0] off_reg, on_reg;
    logic [RGB_W-1:0]    s1_rgb;
    status_t             s1_status;
    status_t             st2_reg, st3_reg;

    // Pipeline flow control
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign load1    = in_valid && in_ready;
    assign load2    = v1_reg && rdy2;
    assign load3    = v2_reg && rdy3;
    assign v1_next  = load1 || (v1_reg && !rdy2);
    assign v2_next  = load2 || (v2_reg && !rdy3);
    assign v3_next  = load3 || (v3_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            off_reg <= '0;
            on_reg  <= '1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_OFF_LEVEL: off_reg <= cfg_data;
                CFG_ON_LEVEL:  on_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Sequencer and first result stage
    rlfs_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load1),
        .operation  (operation),
        .color      (color),
        .pause      (pause),
        .res_rgb    (s1_rgb),
        .res_status (s1_status)
    );

    // Status travels alongside the scaling stages
    always_ff @(posedge clk)
    begin
        if (load2) begin
            st2_reg <= s1_status;
        end
        if (load3) begin
            st3_reg <= st2_reg;
        end
    end

    // Per-channel level scaling
    rlfs_scale #(.PWM_BITS(PWM_BITS)) u_scale_red (
        .clk       (clk),
        .load_mul  (load2),
        .load_out  (load3),
        .ch        (s1_rgb[23:16]),
        .off_level (off_reg),
        .on_level  (on_reg),
        .level     (red_drive)
    );

    rlfs_scale #(.PWM_BITS(PWM_BITS)) u_scale_green (
        .clk       (clk),
        .load_mul  (load2),
        .load_out  (load3),
        .ch        (s1_rgb[15:8]),
        .off_level (off_reg),
        .on_level  (on_reg),
        .level     (green_drive)
    );

    rlfs_scale #(.PWM_BITS(PWM_BITS)) u_scale_blue (
        .clk       (clk),
        .load_mul  (load2),
        .load_out  (load3),
        .ch        (s1_rgb[7:0]),
        .off_level (off_reg),
        .on_level  (on_reg),
        .level     (blue_drive)
    );

    assign out_valid = v3_reg;
    assign busy_res  = st3_reg.busy;
    assign rejected  = st3_reg.rejected;

    // A dropped command leaves the running sequence in place
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> busy_res)
        else $error("rejected result without busy");

    // A full, stalled pipeline takes no new transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && !out_ready) |-> !in_ready)
        else $error("input taken while pipeline full");

    // A result stalled at the output is not lost
    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !out_ready) |=> v3_reg)
        else $error("stalled result dropped");

    // Stage two is loaded only when it is free or draining
    assert property (@(posedge clk) disable iff (!rst_n)
        load2 |-> (!v2_reg || load3))
        else $error("stage two overwritten");

endmodule
